>>> rtl/core/descriptor_driven_touch_report_parser_defines.svh
// Assertion macros for the touch report parser.
`ifndef DESCRIPTOR_DRIVEN_TOUCH_REPORT_PARSER_DEFINES_SVH
`define DESCRIPTOR_DRIVEN_TOUCH_REPORT_PARSER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define DTRP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define DTRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> rtl/core/dtrp_pkg.sv
//------------------------------------------------------------------------------
// dtrp_pkg
// Shared constants of the touch report parser.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package dtrp_pkg;
	localparam logic [7:0] CODE_END      = 8'd0;
	localparam logic [7:0] CODE_LOOP_ACT = 8'd1;
	localparam logic [7:0] CODE_LOOP_ALL = 8'd2;
	localparam logic [7:0] CODE_LOOP_END = 8'd3;
	localparam logic [7:0] CODE_PAD      = 8'd4;
	localparam logic [7:0] CODE_INDEX    = 8'd6;
	localparam logic [7:0] CODE_CLASS    = 8'd7;
	localparam logic [7:0] CODE_X        = 8'd8;
	localparam logic [7:0] CODE_Y        = 8'd9;
	localparam logic [7:0] CODE_Z        = 8'd10;
	localparam logic [7:0] CODE_WIDTH_A  = 8'd11;
	localparam logic [7:0] CODE_WIDTH_B  = 8'd12;
	localparam logic [7:0] CODE_COUNT    = 8'd24;
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FIELD   = 2'd1;
	localparam logic [1:0] ST_LIMIT   = 2'd2;
	localparam int REG_LENGTH = 0;
	localparam int REG_SLOTS  = 1;
	localparam logic [7:0] SAT_MAX = 8'd255;
endpackage

>>> rtl/core/dtrp_ram.sv
//------------------------------------------------------------------------------
// dtrp_ram
// Single write port, single registered read port RAM.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module dtrp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/core/descriptor_driven_touch_report_parser.sv
//------------------------------------------------------------------------------
// descriptor_driven_touch_report_parser
// Loads a descriptor table and a touch report, walks the descriptor over the
// report on the last byte and emits one record per touch slot.
//------------------------------------------------------------------------------
// channel | dir | handshake        | payload
// s_axis  | in  | tvalid/tready    | tdata {byte_value,table_addr}, tuser cmd, tlast last_byte
// m_axis  | out | tvalid/tready    | tdata slot record, tuser parse_status, tlast last_slot
// cfg     | in  | cfg_valid/ready  | cfg_index, cfg_data
// Table writes and report bytes are taken one per cycle while idle; the last byte
// starts the parse when the length is nonzero. A field or unknown code also reads a
// size byte, and a field gathers its bits from up to five report bytes. A zero active
// count skips body codes up to the loop end; a clear state then resets the byte count,
// and one result leaves per cycle while m_axis_tready is high.
// Reset clears control state; table and report memories hold garbage until written.
// s_axis_tready stays low from a parse's last byte until the last slot record is taken.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "descriptor_driven_touch_report_parser_defines.svh"
module descriptor_driven_touch_report_parser import dtrp_pkg::*; #(
	parameter int MAX_SLOTS    = 10,
	parameter int REPORT_BYTES = 512,
	parameter int TABLE_BYTES  = 256,
	parameter int STEP_LIMIT   = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // table_addr[7:0], byte_value[15:8]
	input  logic        s_axis_tuser,   // cmd
	input  logic        s_axis_tlast,   // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [87:0] m_axis_tdata,   // slot_index[3:0], slot_active[4],
	                                    // pos_x[36:5], pos_y[68:37], pressure[76:69],
	                                    // touch_major[84:77], zero fill
	output logic [1:0]  m_axis_tuser,   // parse_status[1:0]
	output logic        m_axis_tlast,   // last_slot
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data
);
	localparam int TA = $clog2(TABLE_BYTES);
	localparam int RA = $clog2(REPORT_BYTES);
	localparam int CW = $clog2(REPORT_BYTES + 1);
	localparam int OW = $clog2(REPORT_BYTES * 8 + 9);
	localparam int SW = $clog2(STEP_LIMIT + 1);
	localparam int IW = $clog2(TABLE_BYTES + 1);
	localparam int LW = $clog2(MAX_SLOTS + 1);
	localparam logic [OW-1:0] OCAP = OW'(REPORT_BYTES * 8 + 8);

	localparam logic [3:0] S_IDLE = 4'd0, S_TREQ = 4'd1, S_CODE = 4'd2,
		S_SREQ = 4'd3, S_SIZE = 4'd4, S_FREQ = 4'd5, S_FBYTE = 4'd6,
		S_APPLY = 4'd7, S_SKREQ = 4'd8, S_SKIP = 4'd9, S_EMIT = 4'd10,
		S_CLEAR = 4'd11;

	logic [3:0]  state_q;
	logic [8:0]  len_cfg_q;
	logic [3:0]  slots_cfg_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] idx_q, loop_q, len_q;
	logic [SW-1:0] steps_q;
	logic [OW-1:0] off_q;
	logic [31:0] obj_q, active_total_q, found_q, val_q;
	logic        only_act_q, have_cnt_q, skip_zero_q;
	logic [7:0]  code_q, width_q;
	logic [5:0]  bit_q;     // field bits gathered so far
	logic [1:0]  status_q;
	logic [LW-1:0] nslots_q, emit_q;
	logic [31:0] sx_q [MAX_SLOTS];
	logic [31:0] sy_q [MAX_SLOTS];
	logic [31:0] sz_q [MAX_SLOTS];
	logic [31:0] sm_q [MAX_SLOTS];
	logic        sf_q [MAX_SLOTS];

	logic in_xfer, cmd, lastb;
	logic [7:0] taddr, bval;
	assign cmd   = s_axis_tuser;
	assign lastb = s_axis_tlast;
	assign taddr = s_axis_tdata[7:0];
	assign bval  = s_axis_tdata[15:8];
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_xfer = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	// Table and report memories; the parse reads both through their own ports
	logic [TA-1:0] t_raddr;
	logic [7:0]    t_rdata, r_rdata;
	logic [RA-1:0] r_raddr;
	dtrp_ram #(.WIDTH(8), .DEPTH(TABLE_BYTES)) u_table (
		.clk(clk), .we(in_xfer && !cmd), .waddr(TA'(taddr)), .wdata(bval),
		.raddr(t_raddr), .rdata(t_rdata));
	dtrp_ram #(.WIDTH(8), .DEPTH(REPORT_BYTES)) u_report (
		.clk(clk), .we(in_xfer && cmd && (cnt_q < CW'(REPORT_BYTES))),
		.waddr(cnt_q[RA-1:0]), .wdata(bval), .raddr(r_raddr), .rdata(r_rdata));
	assign t_raddr = idx_q[TA-1:0];

	// Field bit position
	logic [OW-1:0] fpos;
	assign fpos = off_q + OW'(bit_q);
	assign r_raddr = fpos[RA+2:3];

	logic [OW:0] total_w;
	assign total_w = (OW+1)'({cnt_q, 3'b000});
	logic [OW+8:0] field_end;
	assign field_end = (OW+9)'(off_q) + (OW+9)'(t_rdata);
	logic [OW+8:0] off_add;
	assign off_add = (OW+9)'(off_q) + (OW+9)'(width_q);

	logic is_field;
	always_comb begin
		case (t_rdata)
			CODE_INDEX, CODE_CLASS, CODE_X, CODE_Y, CODE_Z, CODE_WIDTH_A,
			CODE_WIDTH_B, CODE_COUNT: is_field = 1'b1;
			default: is_field = 1'b0;
		endcase
	end

	// Jump back to the loop start at a loop end code
	logic loop_back;
	always_comb begin
		if (only_act_q) begin
			if (have_cnt_q) loop_back = (found_q + 32'd1 < active_total_q);
			else loop_back = ((OW+1)'(off_q) < total_w);
		end else begin
			loop_back = (obj_q + 32'd1 < 32'(nslots_q));
		end
	end

	// Bits available from the current byte for this field
	logic [3:0] avail, take;
	logic [5:0] remain;
	assign avail  = 4'd8 - {1'b0, fpos[2:0]};
	assign remain = 6'(width_q) - bit_q;
	assign take   = (6'(avail) < remain) ? avail : remain[3:0];
	logic [7:0] chunk;
	assign chunk = (r_rdata >> fpos[2:0]) & ~(8'hFF << take);

	logic [LW-1:0] obj_slot;
	assign obj_slot = obj_q[LW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_cfg_q <= '0;
			slots_cfg_q <= 4'd10;
			cnt_q <= '0;
			status_q <= ST_OK;
			emit_q <= '0;
			for (int i = 0; i < MAX_SLOTS; i++) sf_q[i] <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == 1'(REG_LENGTH)) len_cfg_q <= cfg_data;
				else slots_cfg_q <= cfg_data[3:0];
			end
			case (state_q)
				S_IDLE: if (in_xfer && cmd) begin
					if (lastb && len_cfg_q == 9'd0) cnt_q <= '0;
					else if (cnt_q < CW'(REPORT_BYTES)) cnt_q <= cnt_q + 1'b1;
					if (lastb && len_cfg_q != 9'd0) begin
						len_q <= (32'(len_cfg_q) > TABLE_BYTES) ? IW'(TABLE_BYTES)
							: IW'(len_cfg_q);
						nslots_q <= (slots_cfg_q == 4'd0 ||
							32'(slots_cfg_q) > MAX_SLOTS) ? LW'(MAX_SLOTS)
							: LW'(slots_cfg_q);
						for (int i = 0; i < MAX_SLOTS; i++) begin
							sx_q[i] <= '0; sy_q[i] <= '0; sz_q[i] <= '0;
							sm_q[i] <= '0; sf_q[i] <= 1'b0;
						end
						idx_q <= '0; loop_q <= '0; steps_q <= '0; off_q <= '0;
						obj_q <= '0; active_total_q <= '0; found_q <= '0;
						only_act_q <= 1'b0; have_cnt_q <= 1'b0;
						skip_zero_q <= 1'b0;
						state_q <= S_TREQ;
					end
				end
				S_TREQ: begin
					if (idx_q >= len_q) begin
						status_q <= ST_OK; state_q <= S_CLEAR;
					end else if (skip_zero_q) state_q <= S_SKIP;
					else if (steps_q >= SW'(STEP_LIMIT)) begin
						status_q <= ST_LIMIT; state_q <= S_CLEAR;
					end else state_q <= S_CODE;
				end
				S_SKIP: begin
					// skip to the loop end code after a zero active count
					if (t_rdata == CODE_LOOP_END) skip_zero_q <= 1'b0;
					else idx_q <= idx_q + 1'b1;
					state_q <= S_TREQ;
				end
				S_CODE: begin
					steps_q <= steps_q + 1'b1;
					code_q <= t_rdata;
					case (t_rdata)
						CODE_END: begin status_q <= ST_OK; state_q <= S_CLEAR; end
						CODE_LOOP_ACT, CODE_LOOP_ALL: begin
							idx_q <= idx_q + 1'b1;
							obj_q <= '0; loop_q <= idx_q + 1'b1;
							only_act_q <= (t_rdata == CODE_LOOP_ACT);
							state_q <= S_TREQ;
						end
						CODE_LOOP_END: begin
							if (only_act_q && have_cnt_q) found_q <= found_q + 1'b1;
							if (!only_act_q) obj_q <= obj_q + 1'b1;
							idx_q <= loop_back ? loop_q : idx_q + 1'b1;
							state_q <= S_TREQ;
						end
						CODE_PAD: begin
							idx_q <= idx_q + 1'b1;
							off_q <= (off_q + OW'(7)) & ~OW'(7);
							state_q <= S_TREQ;
						end
						default: begin
							idx_q <= idx_q + 1'b1;
							state_q <= is_field ? S_SREQ : S_SKREQ;
						end
					endcase
				end
				S_SKREQ: begin
					if (idx_q >= len_q) begin status_q <= ST_OK; state_q <= S_CLEAR; end
					else state_q <= S_SIZE;
				end
				S_SREQ: begin
					if (idx_q >= len_q) begin status_q <= ST_LIMIT; state_q <= S_CLEAR; end
					else state_q <= S_SIZE;
				end
				S_SIZE: begin
					idx_q <= idx_q + 1'b1;
					width_q <= t_rdata;
					if (code_q == CODE_INDEX || code_q == CODE_CLASS || code_q == CODE_X
						|| code_q == CODE_Y || code_q == CODE_Z
						|| code_q == CODE_WIDTH_A || code_q == CODE_WIDTH_B
						|| code_q == CODE_COUNT) begin
						if (t_rdata > 8'd32 || field_end > (OW+9)'(total_w)) begin
							status_q <= ST_FIELD; state_q <= S_CLEAR;
						end else begin
							val_q <= '0; bit_q <= '0; state_q <= S_FREQ;
						end
					end else begin
						off_q <= (field_end > (OW+9)'(OCAP)) ? OCAP : field_end[OW-1:0];
						state_q <= S_TREQ;
					end
				end
				S_FREQ: state_q <= (bit_q == 6'(width_q)) ? S_APPLY : S_FBYTE;
				S_FBYTE: begin
					val_q <= val_q | (32'(chunk) << bit_q);
					bit_q <= bit_q + 6'(take);
					state_q <= S_FREQ;
				end
				S_APPLY: begin
					off_q <= (off_add > (OW+9)'(OCAP)) ? OCAP : off_add[OW-1:0];
					state_q <= S_TREQ;
					if (code_q == CODE_INDEX) obj_q <= val_q;
					else if (code_q == CODE_COUNT) begin
						active_total_q <= val_q; have_cnt_q <= 1'b1;
						if (val_q == 0 && only_act_q) skip_zero_q <= 1'b1;
					end else if (obj_q < 32'(MAX_SLOTS)) begin
						case (code_q)
							CODE_CLASS: sf_q[obj_slot] <= (val_q != 0);
							CODE_X: sx_q[obj_slot] <= val_q;
							CODE_Y: sy_q[obj_slot] <= val_q;
							CODE_Z: sz_q[obj_slot] <= val_q;
							default: if (val_q > sm_q[obj_slot]) sm_q[obj_slot] <= val_q;
						endcase
					end
				end
				S_CLEAR: begin
					cnt_q <= '0; emit_q <= '0; state_q <= S_EMIT;
				end
				S_EMIT: if (m_axis_tready) begin
					if (emit_q + 1'b1 == nslots_q) state_q <= S_IDLE;
					emit_q <= emit_q + 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output record for the slot being emitted
	logic [LW-1:0] es;
	logic          act;
	logic [31:0]   ox, oy, oz, om;
	assign es  = emit_q;
	assign act = sf_q[es];
	assign ox = act ? sx_q[es] : '0;
	assign oy = act ? sy_q[es] : '0;
	assign oz = act ? sz_q[es] : '0;
	assign om = act ? sm_q[es] : '0;
	assign m_axis_tvalid = (state_q == S_EMIT);
	assign m_axis_tuser  = status_q;
	assign m_axis_tlast  = (emit_q + 1'b1 == nslots_q);
	assign m_axis_tdata = {3'b000,
		(om > 32'(SAT_MAX)) ? SAT_MAX : om[7:0],
		(oz > 32'(SAT_MAX)) ? SAT_MAX : oz[7:0],
		oy, ox, act, 4'(emit_q)};

	`DTRP_ASSERT_IMP(a_no_ready_busy, clk, arst_n, state_q != S_IDLE, !s_axis_tready, "ready while busy")
	`DTRP_ASSERT_IMP(a_emit_range, clk, arst_n, m_axis_tvalid, emit_q < nslots_q, "slot beyond count")
	`DTRP_ASSERT_NEXT(a_last_idle, clk, arst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast, state_q == S_IDLE, "no return to idle")
endmodule

>>> sim/tb.sv
//------------------------------------------------------------------------------
// tb
// Self-checking bench for the touch report parser: loads descriptor tables and
// reports over the input stream, predicts every slot record and compares it
// field by field with the output stream under random idle and stall.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb import dtrp_pkg::*;;
	localparam int MAX_SLOTS    = 10;
	localparam int REPORT_BYTES = 512;
	localparam int TABLE_BYTES  = 256;
	localparam int STEP_LIMIT   = 4096;
	localparam int OFFSET_CAP   = REPORT_BYTES * 8 + 8;

	typedef struct {
		logic       cmd;
		logic [7:0] addr;
		logic [7:0] val;
		logic       last;
	} bus_item_t;

	typedef struct {
		logic [3:0]  slot_index;
		logic        slot_active;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [7:0]  pressure;
		logic [7:0]  touch_major;
		logic [1:0]  parse_status;
		logic        last_slot;
	} slot_rec_t;

	typedef logic [7:0] byte_q_t[$];

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [87:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [8:0]  cfg_data = '0;

	descriptor_driven_touch_report_parser u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),   // table_addr[7:0], byte_value[15:8]
		.s_axis_tuser (s_axis_tuser),   // cmd
		.s_axis_tlast (s_axis_tlast),   // last_byte
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),   // slot_index, slot_active, pos_x, pos_y,
		                                // pressure, touch_major
		.m_axis_tuser (m_axis_tuser),   // parse_status
		.m_axis_tlast (m_axis_tlast),   // last_slot
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	// Pending bus items and the slot records they are predicted to produce.
	bus_item_t   pending_q[$];
	slot_rec_t   slot_rec_q[$];
	int unsigned n_issued = 0;
	int unsigned n_accepted = 0;
	int unsigned send_idle_pct = 20;
	int unsigned recv_stall_pct = 73;
	int unsigned n_errors = 0;
	int unsigned n_reports = 0;
	int unsigned n_records = 0;
	int unsigned n_status[4] = '{0, 0, 0, 0};

	// Shadow of the parser state.
	logic [7:0]  shadow_table[TABLE_BYTES];
	logic [7:0]  shadow_report[REPORT_BYTES];
	int unsigned shadow_count = 0;
	int unsigned desc_len = 0;
	int unsigned slot_cfg = 10;
	logic [31:0] sx[MAX_SLOTS], sy[MAX_SLOTS], sz[MAX_SLOTS], smaj[MAX_SLOTS];
	logic        sflag[MAX_SLOTS];
	int unsigned bit_off;
	logic [31:0] obj_idx;

	function automatic void bump_offset(int unsigned n);
		bit_off = bit_off + n;
		if (bit_off > OFFSET_CAP)
			bit_off = OFFSET_CAP;
	endfunction

	// Walk the descriptor over the buffered report; return the end status.
	function automatic logic [1:0] walk_descriptor(int unsigned len, int unsigned slots);
		int unsigned total, idx, loop_start, steps, active_total, found, width, p, s;
		logic [31:0] val;
		logic [7:0]  code;
		bit          only_active, have_count;
		total = shadow_count * 8;
		idx = 0; loop_start = 0; steps = 0; active_total = 0; found = 0;
		only_active = 1'b0; have_count = 1'b0;
		bit_off = 0;
		obj_idx = '0;
		while (idx < len) begin
			if (steps >= STEP_LIMIT)
				return ST_LIMIT;
			steps++;
			code = shadow_table[idx];
			idx++;
			if (code == CODE_END)
				return ST_OK;
			if (code == CODE_LOOP_ACT || code == CODE_LOOP_ALL) begin
				obj_idx = '0;
				loop_start = idx;
				only_active = (code == CODE_LOOP_ACT);
				continue;
			end
			if (code == CODE_LOOP_END) begin
				if (only_active) begin
					if (have_count) begin
						found++;
						if (found < active_total)
							idx = loop_start;
					end else if (bit_off < total) begin
						idx = loop_start;
					end
				end else begin
					obj_idx++;
					if (obj_idx < slots)
						idx = loop_start;
				end
				continue;
			end
			if (code == CODE_PAD) begin
				bit_off = (bit_off + 7) & ~32'd7;
				continue;
			end
			if ((code >= CODE_INDEX && code <= CODE_WIDTH_B) || code == CODE_COUNT) begin
				if (idx >= len)
					return ST_LIMIT;
				width = 32'(shadow_table[idx]);
				idx++;
				if (width > 32 || bit_off + width > total)
					return ST_FIELD;
				val = '0;
				for (int i = 0; i < width; i++) begin
					p = bit_off + i;
					val[i] = shadow_report[p >> 3][p & 7];
				end
				bump_offset(width);
				if (code == CODE_INDEX) begin
					obj_idx = val;
				end else if (code == CODE_COUNT) begin
					active_total = val;
					have_count = 1'b1;
					// A zero count skips the loop body.
					if (val == 0 && only_active)
						while (idx < len && shadow_table[idx] != CODE_LOOP_END)
							idx++;
				end else if (obj_idx < MAX_SLOTS) begin
					s = obj_idx;
					case (code)
						CODE_CLASS: sflag[s] = (val != 0);
						CODE_X:     sx[s] = val;
						CODE_Y:     sy[s] = val;
						CODE_Z:     sz[s] = val;
						default:    if (val > smaj[s]) smaj[s] = val;
					endcase
				end
				continue;
			end
			// Unknown code: skip its size in report bits.
			if (idx < len) begin
				width = 32'(shadow_table[idx]);
				idx++;
				bump_offset(width);
			end
		end
		return ST_OK;
	endfunction

	// Apply one accepted transfer to the shadow state and queue its records.
	function automatic void predict_transfer(bus_item_t it);
		int unsigned len, slots;
		logic [1:0]  status;
		slot_rec_t   r;
		if (!it.cmd) begin
			shadow_table[it.addr] = it.val;
			return;
		end
		if (shadow_count < REPORT_BYTES) begin
			shadow_report[shadow_count] = it.val;
			shadow_count++;
		end
		if (!it.last)
			return;
		n_reports++;
		len = (desc_len > TABLE_BYTES) ? TABLE_BYTES : desc_len;
		if (len == 0) begin
			shadow_count = 0;
			return;
		end
		slots = (slot_cfg == 0 || slot_cfg > MAX_SLOTS) ? MAX_SLOTS : slot_cfg;
		for (int i = 0; i < MAX_SLOTS; i++) begin
			sx[i] = '0; sy[i] = '0; sz[i] = '0; smaj[i] = '0; sflag[i] = 1'b0;
		end
		status = walk_descriptor(len, slots);
		shadow_count = 0;
		n_status[status]++;
		for (int i = 0; i < slots; i++) begin
			r.slot_index   = 4'(i);
			r.slot_active  = sflag[i];
			r.pos_x        = sflag[i] ? sx[i] : '0;
			r.pos_y        = sflag[i] ? sy[i] : '0;
			r.pressure     = !sflag[i] ? 8'd0 : (sz[i] > SAT_MAX) ? SAT_MAX : sz[i][7:0];
			r.touch_major  = !sflag[i] ? 8'd0 : (smaj[i] > SAT_MAX) ? SAT_MAX : smaj[i][7:0];
			r.parse_status = status;
			r.last_slot    = (i + 1 == slots);
			slot_rec_q.push_back(r);
		end
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
			n_errors++;
		end
	endfunction

	// Input driver: advance to the next item once the current transfer is done.
	always @(negedge clk) begin
		if (!s_axis_tvalid || n_accepted == n_issued) begin
			if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				s_axis_tdata  <= {pending_q[0].val, pending_q[0].addr};
				s_axis_tuser  <= pending_q[0].cmd;
				s_axis_tlast  <= pending_q[0].last;
				s_axis_tvalid <= 1'b1;
				void'(pending_q.pop_front());
				n_issued++;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Monitor: check outgoing records, then predict from the input transfer.
	always @(posedge clk) begin
		slot_rec_t  e;
		bus_item_t  it;
		if (m_axis_tvalid && m_axis_tready) begin
			n_records++;
			if (slot_rec_q.size() == 0) begin
				$error("slot record with nothing expected: 0x%0h", m_axis_tdata);
				n_errors++;
			end else begin
				e = slot_rec_q.pop_front();
				check_field("slot_index", 32'(e.slot_index), 32'(m_axis_tdata[3:0]));
				check_field("slot_active", 32'(e.slot_active), 32'(m_axis_tdata[4]));
				check_field("pos_x", e.pos_x, m_axis_tdata[36:5]);
				check_field("pos_y", e.pos_y, m_axis_tdata[68:37]);
				check_field("pressure", 32'(e.pressure), 32'(m_axis_tdata[76:69]));
				check_field("touch_major", 32'(e.touch_major), 32'(m_axis_tdata[84:77]));
				check_field("last_slot", 32'(e.last_slot), 32'(m_axis_tlast));
				check_field("parse_status", 32'(e.parse_status), 32'(m_axis_tuser));
			end
		end
		if (s_axis_tvalid && s_axis_tready) begin
			it.addr = s_axis_tdata[7:0];
			it.val  = s_axis_tdata[15:8];
			it.cmd  = s_axis_tuser;
			it.last = s_axis_tlast;
			predict_transfer(it);
			n_accepted++;
		end
	end

	task automatic put_item(logic cmd, logic [7:0] addr, logic [7:0] val, logic last);
		bus_item_t it;
		it.cmd = cmd; it.addr = addr; it.val = val; it.last = last;
		pending_q.push_back(it);
	endtask

	task automatic load_table(byte_q_t d);
		foreach (d[i])
			put_item(1'b0, 8'(i), d[i], 1'($urandom_range(1)));
	endtask

	// Queue one report of n bytes; fill selects 0 = random, 1 = all ones, 2 = zeros.
	task automatic send_report(int unsigned n, int fill);
		logic [7:0] b;
		for (int i = 0; i < n; i++) begin
			b = (fill == 1) ? 8'hFF : (fill == 2) ? 8'h00 : 8'($urandom);
			put_item(1'b1, 8'($urandom), b, i == n - 1);
		end
	endtask

	// Hold until every queued transfer is taken and every record has come,
	// then let a zero-length parse finish before touching registers.
	task automatic wait_drained();
		while (pending_q.size() != 0 || n_accepted != n_issued || slot_rec_q.size() != 0
				|| s_axis_tvalid)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(int idx, int unsigned data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= 1'(idx);
		cfg_data  <= 9'(data);
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_LENGTH)
			desc_len = data & 9'h1FF;
		else
			slot_cfg = data & 4'hF;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic int unsigned pick_width();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60)
			return $urandom_range(1, 12);
		if (r < 96)
			return $urandom_range(13, 32);
		return $urandom_range(33, 40);
	endfunction

	// Build a random descriptor; bits returns the report bits one object needs.
	task automatic build_descriptor(output byte_q_t d, output int unsigned bits);
		int unsigned w;
		int unsigned kind;
		d = {};
		bits = 0;
		kind = $urandom_range(3);
		if ($urandom_range(3) == 0) begin
			// Unknown code skipped by its size.
			w = $urandom_range(0, 16);
			d.push_back(8'($urandom_range(13, 255)) == CODE_COUNT ? 8'd200 : 8'($urandom_range(13, 23)));
			d.push_back(8'(w));
			bits += w;
		end
		case (kind)
			0, 1: begin
				if (kind == 1) begin
					d.push_back(CODE_COUNT); d.push_back(8'd4); bits += 4;
					d.push_back(CODE_LOOP_ACT);
				end else begin
					d.push_back(CODE_LOOP_ALL);
				end
				if ($urandom_range(1)) begin
					d.push_back(CODE_INDEX); d.push_back(8'd4); bits += 4;
				end
				d.push_back(CODE_CLASS); d.push_back(8'd1); bits += 1;
				for (int c = CODE_X; c <= CODE_WIDTH_B; c++) begin
					w = pick_width();
					d.push_back(8'(c)); d.push_back(8'(w)); bits += w;
				end
				if ($urandom_range(1)) begin
					d.push_back(CODE_PAD); bits += 7;
				end
				d.push_back(CODE_LOOP_END);
				d.push_back(CODE_END);
			end
			2: begin
				// Active loop without a count runs until the report is used up.
				d.push_back(CODE_LOOP_ACT);
				d.push_back(CODE_CLASS); d.push_back(8'd1);
				d.push_back(CODE_X); d.push_back(8'd16);
				d.push_back(CODE_Y); d.push_back(8'd15);
				d.push_back(CODE_LOOP_END);
				bits = 32;
			end
			default: begin
				for (int i = 0; i < $urandom_range(4, 20); i++) begin
					case ($urandom_range(3))
						0: d.push_back(8'($urandom_range(0, 12)));
						1: d.push_back(CODE_COUNT);
						default: d.push_back(8'($urandom));
					endcase
					d.push_back(8'($urandom_range(0, 40)));
				end
				bits = 64;
			end
		endcase
	endtask

	initial begin
		byte_q_t     d;
		int unsigned bits, slots, n;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// All-object loop with full-width fields: all ones and all zeros.
		d = '{CODE_LOOP_ALL, CODE_CLASS, 8'd1, CODE_X, 8'd32, CODE_Y, 8'd32, CODE_Z, 8'd32,
			CODE_WIDTH_A, 8'd32, CODE_WIDTH_B, 8'd8, CODE_PAD, CODE_LOOP_END, CODE_END};
		load_table(d);
		wait_drained();
		write_reg(REG_LENGTH, d.size());
		write_reg(REG_SLOTS, 1);
		send_report(18, 1);
		send_report(18, 2);
		// Short report: field overruns the end.
		send_report(3, 0);
		wait_drained();

		// Field wider than 32 bits, then a table that starts with an end code.
		d = '{CODE_LOOP_ALL, CODE_X, 8'd33, CODE_LOOP_END, CODE_END, CODE_Y};
		load_table(d);
		wait_drained();
		write_reg(REG_SLOTS, 0);
		write_reg(REG_LENGTH, 4);
		send_report(8, 0);
		wait_drained();
		write_reg(REG_LENGTH, 6);
		d = '{CODE_END, CODE_Y};
		load_table(d);
		send_report(2, 0);
		// Unknown code at the very end ends normally.
		d = '{8'd5, 8'd3, 8'd200};
		load_table(d);
		wait_drained();
		write_reg(REG_LENGTH, 3);
		write_reg(REG_SLOTS, 15);
		send_report(2, 0);
		wait_drained();

		// Active loop with no count and no consumed bits never exits: step limit.
		d = '{CODE_LOOP_ACT, CODE_LOOP_END};
		load_table(d);
		wait_drained();
		write_reg(REG_LENGTH, 2);
		write_reg(REG_SLOTS, 1);
		send_report(1, 0);
		// Zero active count skips the body; an index out of range is discarded.
		d = '{CODE_COUNT, 8'd4, CODE_LOOP_ACT, CODE_CLASS, 8'd1, CODE_LOOP_END,
			CODE_LOOP_ALL, CODE_INDEX, 8'd4, CODE_CLASS, 8'd1, CODE_X, 8'd8, CODE_LOOP_END,
			CODE_END};
		load_table(d);
		wait_drained();
		write_reg(REG_LENGTH, d.size());
		write_reg(REG_SLOTS, 10);
		put_item(1'b1, 8'h00, 8'hF0, 1'b0);
		put_item(1'b1, 8'h00, 8'hFF, 1'b0);
		send_report(15, 0);
		wait_drained();
		// Zero length gives no records; an oversized length saturates.
		write_reg(REG_LENGTH, 0);
		send_report(2, 0);
		wait_drained();
		write_reg(REG_LENGTH, 511);
		send_report(4, 0);
		// Pause the sender until everything expected has come out.
		wait_drained();

		// Random phases: mostly well-formed descriptors with random contents.
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin
				send_idle_pct = 73; recv_stall_pct = 20;
			end else if (ph == 2) begin
				send_idle_pct = 0; recv_stall_pct = 0;
			end
			build_descriptor(d, bits);
			load_table(d);
			wait_drained();
			slots = $urandom_range(1, 2);
			write_reg(REG_SLOTS, slots);
			n = d.size();
			if ($urandom_range(7) == 0)
				n = $urandom_range(0, d.size());
			write_reg(REG_LENGTH, n);
			if ($urandom_range(4) == 0)
				n = $urandom_range(1, 16);
			else
				n = (bits * slots + 7) / 8 + $urandom_range(0, 4);
			send_report(n, 0);
			wait_drained();
		end

		repeat (100) @(posedge clk);
		$display("covered %0d reports, %0d slot records checked", n_reports, n_records);
		$display("parse endings: %0d normal, %0d field error, %0d limit or missing size",
			n_status[0], n_status[1], n_status[2]);
		if (n_errors == 0 && slot_rec_q.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("tb failed");
		$finish;
	end
endmodule
